// ===== rtl/akf_pkg.sv =====
// shared types and constants of the angle and gyro kalman fusion block
package akf_pkg;

  // configuration registers are unsigned q0.32
  localparam int CFG_WIDTH = 32;
  localparam int CFG_FRAC  = 32;
  localparam int IDX_WIDTH = 2;

  // register indexes
  localparam logic [IDX_WIDTH-1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_MEASURE_NOISE = 2'd2;
  localparam logic [IDX_WIDTH-1:0] REG_SAMPLE_PERIOD = 2'd3;

  // register reset values
  localparam logic [CFG_WIDTH-1:0] ANGLE_NOISE_RST   = 32'd171798692;
  localparam logic [CFG_WIDTH-1:0] BIAS_NOISE_RST    = 32'd21474836;
  localparam logic [CFG_WIDTH-1:0] MEASURE_NOISE_RST = 32'd214748365;
  localparam logic [CFG_WIDTH-1:0] SAMPLE_PERIOD_RST = 32'd21474836;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] angle_noise;
    logic [CFG_WIDTH-1:0] bias_noise;
    logic [CFG_WIDTH-1:0] measure_noise;
    logic [CFG_WIDTH-1:0] sample_period;
  } cfg_t;

  // multiply operations of one filter step, in sequence order
  typedef enum logic [3:0] {
    OP_ANG_PRED  = 4'd0,
    OP_COV_AA    = 4'd1,
    OP_COV_AB    = 4'd2,
    OP_COV_BB    = 4'd3,
    OP_K0_AA     = 4'd4,
    OP_K0_AB     = 4'd5,
    OP_K1_AA     = 4'd6,
    OP_K1_AB     = 4'd7,
    OP_ANG_CORR  = 4'd8,
    OP_BIAS_CORR = 4'd9
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_apply;
    logic div_start;
    logic out_load;
    op_t  op;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mul_done;
    logic div_done;
  } stat_t;

  // next operation in the sequence
  function automatic op_t next_op(input op_t op);
    op_t n;
    unique case (op)
      OP_ANG_PRED:  n = OP_COV_AA;
      OP_COV_AA:    n = OP_COV_AB;
      OP_COV_AB:    n = OP_COV_BB;
      OP_COV_BB:    n = OP_K0_AA;
      OP_K0_AA:     n = OP_K0_AB;
      OP_K0_AB:     n = OP_K1_AA;
      OP_K1_AA:     n = OP_K1_AB;
      OP_K1_AB:     n = OP_ANG_CORR;
      OP_ANG_CORR:  n = OP_BIAS_CORR;
      OP_BIAS_CORR: n = OP_ANG_PRED;
      default:      n = OP_ANG_PRED;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/akf_mul.sv =====
// sequential magnitude multiplier, sixteen bits of b per cycle, with rounding shift
module akf_mul import akf_pkg::*; #(
  parameter int MW = 48,
  parameter int SC = 44
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MW-1:0]     a_mag,
  input  logic [MW-1:0]     b_mag,
  input  logic              neg,
  input  logic              cov_frac,
  output logic              done,
  output logic [2*MW:0]     res_mag,
  output logic              res_neg
);

  localparam int RW = 2 * MW + 1;
  localparam int ND = (MW + 15) / 16;
  localparam int BW = ND * 16;
  localparam int CW = (ND > 1) ? $clog2(ND) : 1;
  localparam logic [RW-1:0] RND_C = RW'(1) << (SC - 1);
  localparam logic [RW-1:0] RND_S = RW'(1) << (CFG_FRAC - 1);

  logic [MW-1:0]    a_r;
  logic [BW-1:0]    b_r;
  logic [RW-1:0]    acc;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             fin;
  logic             cov_r;
  logic [MW+15:0]   pp;

  // one partial product a by a sixteen bit digit of b
  assign pp = a_r * b_r[15:0];

  // accumulate digits, then round and shift
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r     <= a_mag;
        b_r     <= BW'(b_mag);
        acc     <= '0;
        cnt     <= '0;
        busy    <= 1'b1;
        res_neg <= neg;
        cov_r   <= cov_frac;
      end else if (busy) begin
        acc <= acc + (RW'(pp) << {cnt, 4'b0000});
        b_r <= b_r >> 16;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ND - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        if (cov_r) begin
          res_mag <= (acc + RND_C) >> SC;
        end else begin
          res_mag <= (acc + RND_S) >> CFG_FRAC;
        end
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/akf_div.sv =====
// dual restoring divider forming both gains against one divisor, one bit per cycle
module akf_div import akf_pkg::*; #(
  parameter int C = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [C-1:0]        den,
  input  logic                den_pos,
  input  logic [C-1:0]        n0_mag,
  input  logic                n0_neg,
  input  logic [C-1:0]        n1_mag,
  input  logic                n1_neg,
  output logic                done,
  output logic signed [C-1:0] k0,
  output logic signed [C-1:0] k1
);

  localparam int NW = $clog2(C + 1);
  localparam logic [C-1:0] KMIN = {1'b1, {(C-1){1'b0}}};
  localparam logic [C-1:0] KMAX = {1'b0, {(C-1){1'b1}}};

  logic [C-1:0] den_r;
  logic         pos_r;
  logic [C-1:0] rem [2];
  logic [C-1:0] quo [2];
  logic [C-1:0] nb  [2];
  logic         ovf [2];
  logic         nr  [2];
  logic [C:0]   r2  [2];
  logic         ge  [2];
  logic [NW-1:0] cnt;
  logic         busy;
  logic         fin;

  // saturate a quotient magnitude to a signed gain
  function automatic logic [C-1:0] q_sat(input logic neg, input logic of,
                                         input logic [C-1:0] q);
    logic [C-1:0] nq;
    nq = ~q + 1'b1;
    if (neg) begin
      if (of || (q[C-1] && |q[C-2:0])) return KMIN;
      return nq;
    end
    if (of || q[C-1]) return KMAX;
    return q;
  endfunction

  // trial subtraction for each lane
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      r2[i] = {rem[i], nb[i][C-1]};
      ge[i] = r2[i] >= {1'b0, den_r};
    end
  end

  // the numerator is |n| << (C-4); its top part |n| >> 4 gives the start remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r  <= den;
        pos_r  <= den_pos;
        rem[0] <= n0_mag >> 4;
        rem[1] <= n1_mag >> 4;
        ovf[0] <= (n0_mag >> 4) >= den;
        ovf[1] <= (n1_mag >> 4) >= den;
        nb[0]  <= {n0_mag[3:0], {(C-4){1'b0}}};
        nb[1]  <= {n1_mag[3:0], {(C-4){1'b0}}};
        nr[0]  <= n0_neg;
        nr[1]  <= n1_neg;
        quo[0] <= '0;
        quo[1] <= '0;
        cnt    <= NW'(C);
        busy   <= 1'b1;
      end else if (busy) begin
        for (int i = 0; i < 2; i++) begin
          if (ge[i]) begin
            rem[i] <= C'(r2[i] - {1'b0, den_r});
          end else begin
            rem[i] <= r2[i][C-1:0];
          end
          quo[i] <= {quo[i][C-2:0], ge[i]};
          nb[i]  <= nb[i] << 1;
        end
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        k0   <= pos_r ? q_sat(nr[0], ovf[0], quo[0]) : '0;
        k1   <= pos_r ? q_sat(nr[1], ovf[1], quo[1]) : '0;
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/akf_dpath.sv =====
// datapath: filter state, operand selection, write-back and output registers
module akf_dpath import akf_pkg::*; #(
  parameter int W = 32,
  parameter int C = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output stat_t        stat,
  input  cfg_t         cfg,
  input  logic [W-1:0] angle_meas,
  input  logic [W-1:0] gyro_meas,
  output logic [W-1:0] angle_est,
  output logic [W-1:0] rate_est
);

  localparam int MW0 = (C > W + 1) ? C : W + 1;
  localparam int MW  = (MW0 > CFG_WIDTH) ? MW0 : CFG_WIDTH + 1;
  localparam int RW  = 2 * MW + 1;
  localparam int SF  = C - 4;
  localparam int CSH_L = (SF >= CFG_FRAC) ? SF - CFG_FRAC : 0;
  localparam int CSH_R = (SF >= CFG_FRAC) ? 0 : CFG_FRAC - SF;
  localparam bit E_CLAMP = (C >= 64);
  localparam logic [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};
  localparam logic [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] COV_ONE = C'(1) << SF;
  localparam logic signed [W+2:0] SMAX = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] SMIN = {4'b1111, {(W-1){1'b0}}};
  localparam logic [RW-1:0] CLIM = RW'(1) << (C - 1);
  localparam logic [RW-1:0] SLIM = RW'(1) << (W + 1);

  logic signed [W-1:0] am, gm, angle, bias;
  logic signed [C-1:0] aa, ab, ba, bb, t0, t1;
  logic signed [W:0]   err;

  logic signed [C-1:0] an_c, bn_c, mn_c, pd0, pd1;
  logic signed [W:0]   d;
  logic signed [MW-1:0] opa, opb;
  logic                cov_frac;
  logic signed [C:0]   e_sum;
  logic [C-1:0]        den;
  logic                den_pos;
  logic [RW-1:0]       m_mag;
  logic                m_neg;
  logic signed [C-1:0] r_c;
  logic signed [W+1:0] r_s;
  logic signed [C-1:0] k0, k1;

  function automatic logic signed [C-1:0] sat_c(input logic signed [C:0] x);
    if (x[C] != x[C-1]) return x[C] ? CMIN : CMAX;
    return x[C-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [W+2:0] x);
    if (x > SMAX) return SMAX[W-1:0];
    if (x < SMIN) return SMIN[W-1:0];
    return x[W-1:0];
  endfunction

  // register value in covariance format
  function automatic logic signed [C-1:0] cfg_cov(input logic [CFG_WIDTH-1:0] v);
    logic [C+CFG_WIDTH-1:0] ext;
    ext = (C + CFG_WIDTH)'(v);
    ext = (ext << CSH_L) >> CSH_R;
    return ext[C-1:0];
  endfunction

  function automatic logic [MW-1:0] abs_m(input logic signed [MW-1:0] x);
    logic [MW-1:0] u;
    u = x;
    return x[MW-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic [C-1:0] abs_c(input logic signed [C-1:0] x);
    logic [C-1:0] u;
    u = x;
    return x[C-1] ? (~u + 1'b1) : u;
  endfunction

  // product magnitude to a signed value, saturated
  function automatic logic signed [C-1:0] clamp_c(input logic [RW-1:0] m, input logic ng);
    logic [RW-1:0] t;
    t = ~m + 1'b1;
    if (ng) return (m >= CLIM) ? CMIN : t[C-1:0];
    return (m >= CLIM) ? CMAX : m[C-1:0];
  endfunction

  function automatic logic signed [W+1:0] clamp_s(input logic [RW-1:0] m, input logic ng);
    logic [RW-1:0] t;
    t = ~m + 1'b1;
    if (ng) return (m >= SLIM) ? {1'b1, {(W+1){1'b0}}} : t[W+1:0];
    return (m >= SLIM) ? {1'b0, {(W+1){1'b1}}} : m[W+1:0];
  endfunction

  // derived terms of the prediction
  assign an_c = cfg_cov(cfg.angle_noise);
  assign bn_c = cfg_cov(cfg.bias_noise);
  assign mn_c = cfg_cov(cfg.measure_noise);
  assign d    = (W+1)'(gm) - (W+1)'(bias);
  assign pd0  = sat_c((C+1)'(sat_c((C+1)'(an_c) - (C+1)'(ab))) - (C+1)'(ba));
  assign pd1  = sat_c((C+1)'(0) - (C+1)'(bb));

  // innovation divisor
  assign e_sum   = (C+1)'(mn_c) + (C+1)'(aa);
  assign den_pos = !e_sum[C] && (|e_sum[C-1:0]);
  assign den     = (E_CLAMP && e_sum[C-1] && !e_sum[C]) ? CMAX : e_sum[C-1:0];

  // multiplier operand selection
  always_comb begin
    opa      = MW'(d);
    opb      = MW'(cfg.sample_period);
    cov_frac = 1'b0;
    unique case (cmd.op)
      OP_ANG_PRED: begin
        opa = MW'(d);
      end
      OP_COV_AA: begin
        opa = MW'(pd0);
      end
      OP_COV_AB: begin
        opa = MW'(pd1);
      end
      OP_COV_BB: begin
        opa = MW'(bn_c);
      end
      OP_K0_AA: begin
        opa = MW'(k0); opb = MW'(t0); cov_frac = 1'b1;
      end
      OP_K0_AB: begin
        opa = MW'(k0); opb = MW'(t1); cov_frac = 1'b1;
      end
      OP_K1_AA: begin
        opa = MW'(k1); opb = MW'(t0); cov_frac = 1'b1;
      end
      OP_K1_AB: begin
        opa = MW'(k1); opb = MW'(t1); cov_frac = 1'b1;
      end
      OP_ANG_CORR: begin
        opa = MW'(k0); opb = MW'(err); cov_frac = 1'b1;
      end
      OP_BIAS_CORR: begin
        opa = MW'(k1); opb = MW'(err); cov_frac = 1'b1;
      end
      default: begin
        opa = MW'(d);
      end
    endcase
  end

  akf_mul #(.MW(MW), .SC(SF)) u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mul_start),
    .a_mag    (abs_m(opa)),
    .b_mag    (abs_m(opb)),
    .neg      (opa[MW-1] ^ opb[MW-1]),
    .cov_frac (cov_frac),
    .done     (stat.mul_done),
    .res_mag  (m_mag),
    .res_neg  (m_neg)
  );

  akf_div #(.C(C)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .den     (den),
    .den_pos (den_pos),
    .n0_mag  (abs_c(aa)),
    .n0_neg  (aa[C-1]),
    .n1_mag  (abs_c(ba)),
    .n1_neg  (ba[C-1]),
    .done    (stat.div_done),
    .k0      (k0),
    .k1      (k1)
  );

  assign r_c = clamp_c(m_mag, m_neg);
  assign r_s = clamp_s(m_mag, m_neg);

  // filter state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      aa    <= COV_ONE;
      ab    <= '0;
      ba    <= '0;
      bb    <= COV_ONE;
    end else if (cmd.mul_apply) begin
      unique case (cmd.op)
        OP_ANG_PRED:  angle <= sat_w((W+3)'(angle) + (W+3)'(r_s));
        OP_COV_AA:    aa <= sat_c((C+1)'(aa) + (C+1)'(r_c));
        OP_COV_AB: begin
          ab <= sat_c((C+1)'(ab) + (C+1)'(r_c));
          ba <= sat_c((C+1)'(ba) + (C+1)'(r_c));
        end
        OP_COV_BB:    bb <= sat_c((C+1)'(bb) + (C+1)'(r_c));
        OP_K0_AA:     aa <= sat_c((C+1)'(aa) - (C+1)'(r_c));
        OP_K0_AB:     ab <= sat_c((C+1)'(ab) - (C+1)'(r_c));
        OP_K1_AA:     ba <= sat_c((C+1)'(ba) - (C+1)'(r_c));
        OP_K1_AB:     bb <= sat_c((C+1)'(bb) - (C+1)'(r_c));
        OP_ANG_CORR:  angle <= sat_w((W+3)'(angle) + (W+3)'(r_s));
        OP_BIAS_CORR: bias <= sat_w((W+3)'(bias) + (W+3)'(r_s));
        default:      angle <= angle;
      endcase
    end
  end

  // input capture, correction operands and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      am <= angle_meas;
      gm <= gyro_meas;
    end
    if (cmd.div_start) begin
      err <= (W+1)'(am) - (W+1)'(angle);
      t0  <= aa;
      t1  <= ab;
    end
    if (cmd.out_load) begin
      angle_est <= angle;
      rate_est  <= sat_w((W+3)'(gm) - (W+3)'(bias));
    end
  end

endmodule

// ===== rtl/akf_ctrl.sv =====
// controller: sequences the multiply and divide steps and runs both handshakes
module akf_ctrl import akf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MSTART = 6'b000010,
    ST_MWAIT  = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DWAIT  = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // next state and commands
  always_comb begin
    state_next    = state;
    op_next       = op;
    cmd           = '0;
    cmd.op        = op;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          op_next    = OP_ANG_PRED;
          state_next = ST_MSTART;
        end
      end
      ST_MSTART: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat.mul_done) begin
          cmd.mul_apply = 1'b1;
          op_next       = next_op(op);
          if (op == OP_COV_BB) begin
            state_next = ST_DSTART;
          end else if (op == OP_BIAS_CORR) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_MSTART;
          end
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat.div_done) begin
          state_next = ST_MSTART;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state, operation and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= OP_ANG_PRED;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/angle_gyro_kalman_fusion.sv =====
// top level of the angle and gyro rate kalman fusion filter
//
// input stream s_*: one transaction per sensor sample, carrying the
// measured angle and gyro rate in signed q16.16 (at SAMPLE_WIDTH 32).
// output stream m_*: one transaction per sample with the filtered angle
// and the bias-corrected rate, both saturated.
// cfg_we / cfg_index / cfg_data write the four q0.32 registers (angle
// noise, bias noise, measurement noise, sample period); write them only
// while no sample is in flight.
// each sample runs ten multiplies on one shared multiplier, which issues,
// accumulates ceil(MW/16) sixteen bit digits, finishes and writes back,
// MW = max(COV_WIDTH, SAMPLE_WIDTH+1, 33), and one gain division on a dual
// bit-serial divider of COV_WIDTH quotient bits with issue, finish and
// hand-over. one sample is in work at a time and the next is accepted
// only once the result of the last is registered. the result sits in an
// output register, so s_tready rises again while it waits; a stalled
// receiver holds the block only once the next result is ready. reset
// clears the state to angle and bias zero, unit covariance, and restores
// the register defaults.
module angle_gyro_kalman_fusion import akf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COV_WIDTH    = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // fields from bit 0: angle_meas, gyro_meas
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // fields from bit 0: angle_est, rate_est
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int TDW = ((2 * W + 7) / 8) * 8;

  cfg_t         cfg;
  cmd_t         cmd;
  stat_t        stat;
  logic [W-1:0] angle_est;
  logic [W-1:0] rate_est;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_noise   <= ANGLE_NOISE_RST;
      cfg.bias_noise    <= BIAS_NOISE_RST;
      cfg.measure_noise <= MEASURE_NOISE_RST;
      cfg.sample_period <= SAMPLE_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_NOISE:   cfg.angle_noise   <= cfg_data;
        REG_BIAS_NOISE:    cfg.bias_noise    <= cfg_data;
        REG_MEASURE_NOISE: cfg.measure_noise <= cfg_data;
        REG_SAMPLE_PERIOD: cfg.sample_period <= cfg_data;
        default:           cfg.angle_noise   <= cfg.angle_noise;
      endcase
    end
  end

  akf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  akf_dpath #(.W(W), .C(COV_WIDTH)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg),
    .angle_meas (s_tdata[W-1:0]),
    .gyro_meas  (s_tdata[2*W-1:W]),
    .angle_est  (angle_est),
    .rate_est   (rate_est)
  );

  // pack the result with zero fill
  assign m_tdata = TDW'({rate_est, angle_est});

endmodule

// ===== sim/angle_gyro_kalman_fusion_test.sv =====
// testbench for the angle and gyro rate kalman fusion filter
`timescale 1ns / 100ps

module angle_gyro_kalman_fusion_test import akf_pkg::*;;

  localparam int SW = 32;
  localparam int CW = 48;
  localparam int CFRAC = CW - 4;
  localparam int LATENCY = 200;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_index = REG_ANGLE_NOISE;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  angle_gyro_kalman_fusion #(.SAMPLE_WIDTH(SW), .COV_WIDTH(CW)) DUT (.*);

  always #6 clk = ~clk;

  // filter model state and registers
  longint ang_st, bias_st, p_aa, p_ab, p_ba, p_bb;
  longint unsigned r_angle_noise, r_bias_noise, r_meas_noise, r_period;

  logic [63:0] samples_todo[$];
  logic [63:0] results_due[$];
  int errors = 0;
  int results_seen = 0;
  bit quiet = 1'b0;
  bit held_once = 1'b0;
  int hold_left = 0;
  longint cycles = 0;

  function automatic logic [129:0] magn(longint v);
    logic signed [129:0] x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  // clamp a signed magnitude to w bits
  function automatic longint clamp_mag(bit neg, logic [129:0] m, int w);
    logic [129:0] lim;
    logic signed [129:0] r;
    lim = (130'd1 << (w - 1)) - 130'd1 + neg;
    if (m > lim) m = lim;
    r = neg ? -$signed(m) : $signed(m);
    return r[63:0];
  endfunction

  function automatic longint sat_to(logic signed [129:0] v, int w);
    logic signed [129:0] hi, lo;
    hi = (130'sd1 <<< (w - 1)) - 130'sd1;
    lo = -hi - 130'sd1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[63:0];
  endfunction

  function automatic longint add_s(longint a, longint b, int w);
    logic signed [129:0] x, y;
    x = a;
    y = b;
    return sat_to(x + y, w);
  endfunction

  function automatic longint sub_s(longint a, longint b, int w);
    logic signed [129:0] x, y;
    x = a;
    y = b;
    return sat_to(x - y, w);
  endfunction

  // product shifted right with rounding half away from zero
  function automatic longint scaled_product(longint a, longint b, int s, int w);
    logic [129:0] p;
    p = magn(a) * magn(b);
    if (s > 0) p = (p + (130'd1 << (s - 1))) >> s;
    return clamp_mag((a < 0) != (b < 0), p, w);
  endfunction

  function automatic longint gain_quotient(longint n, longint d);
    logic [129:0] q;
    q = (magn(n) << CFRAC) / magn(d);
    return clamp_mag(n < 0, q, CW);
  endfunction

  function automatic longint reg_to_cov(longint unsigned v);
    return longint'(v << (CFRAC - CFG_FRAC));
  endfunction

  // one filter step: returns packed angle_est, rate_est
  function automatic logic [63:0] filter_step(logic [63:0] sample);
    longint am, gm, dt, d0, d1, d3, err, e, k0, k1, t0, t1;
    logic [31:0] ang_out, rate_out;
    am = longint'($signed(sample[31:0]));
    gm = longint'($signed(sample[63:32]));
    dt = longint'(r_period);
    k0 = 0;
    k1 = 0;
    // prediction
    ang_st = add_s(ang_st, scaled_product(gm - bias_st, dt, CFG_FRAC, 64), SW);
    d0 = sub_s(sub_s(reg_to_cov(r_angle_noise), p_ab, CW), p_ba, CW);
    d1 = sub_s(0, p_bb, CW);
    d3 = sat_to(reg_to_cov(r_bias_noise), CW);
    p_aa = add_s(p_aa, scaled_product(d0, dt, CFG_FRAC, CW), CW);
    p_ab = add_s(p_ab, scaled_product(d1, dt, CFG_FRAC, CW), CW);
    p_ba = add_s(p_ba, scaled_product(d1, dt, CFG_FRAC, CW), CW);
    p_bb = add_s(p_bb, scaled_product(d3, dt, CFG_FRAC, CW), CW);
    // correction
    err = am - ang_st;
    e = add_s(reg_to_cov(r_meas_noise), p_aa, 64);
    if (e > 0) begin
      k0 = gain_quotient(p_aa, e);
      k1 = gain_quotient(p_ba, e);
    end
    t0 = p_aa;
    t1 = p_ab;
    p_aa = sub_s(p_aa, scaled_product(k0, t0, CFRAC, CW), CW);
    p_ab = sub_s(p_ab, scaled_product(k0, t1, CFRAC, CW), CW);
    p_ba = sub_s(p_ba, scaled_product(k1, t0, CFRAC, CW), CW);
    p_bb = sub_s(p_bb, scaled_product(k1, t1, CFRAC, CW), CW);
    ang_st = add_s(ang_st, scaled_product(k0, err, CFRAC, 64), SW);
    bias_st = add_s(bias_st, scaled_product(k1, err, CFRAC, 64), SW);
    ang_out = ang_st[31:0];
    rate_out = 32'(sat_to(gm - bias_st, SW));
    return {rate_out, ang_out};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at result %0d", what, got, want,
             results_seen);
    errors++;
  endtask

  // sender: offers queued samples, predicts each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) results_due.push_back(filter_step(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (samples_todo.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
          s_tdata <= samples_todo.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (!held_once && results_seen >= 300) begin
      held_once = 1'b1;
      hold_left = 2000;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  // checker: compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report("unexpected transaction", m_tdata[31:0], 32'd0);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[31:0] !== want[31:0]) report("angle_est", m_tdata[31:0], want[31:0]);
        if (m_tdata[63:32] !== want[63:32])
          report("rate_est", m_tdata[63:32], want[63:32]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ANGLE_NOISE:   r_angle_noise = val;
      REG_BIAS_NOISE:    r_bias_noise = val;
      REG_MEASURE_NOISE: r_meas_noise = val;
      default:           r_period = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] an, logic [31:0] bn, logic [31:0] mn,
                           logic [31:0] sp);
    write_reg(REG_ANGLE_NOISE, an);
    write_reg(REG_BIAS_NOISE, bn);
    write_reg(REG_MEASURE_NOISE, mn);
    write_reg(REG_SAMPLE_PERIOD, sp);
  endtask

  // wait until every expected result is in and the block has settled
  task automatic drain();
    while (samples_todo.size() > 0 || s_tvalid || results_due.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(1 << 23)) - (1 << 22));
    endcase
  endfunction

  task automatic queue_random(int n);
    repeat (n) samples_todo.push_back({rand_sample(), rand_sample()});
  endtask

  initial begin
    r_angle_noise = ANGLE_NOISE_RST;
    r_bias_noise = BIAS_NOISE_RST;
    r_meas_noise = MEASURE_NOISE_RST;
    r_period = SAMPLE_PERIOD_RST;
    ang_st = 0;
    bias_st = 0;
    p_aa = 64'sd1 <<< CFRAC;
    p_ab = 0;
    p_ba = 0;
    p_bb = 64'sd1 <<< CFRAC;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes under the reset registers
    samples_todo.push_back({32'h00000000, 32'h00000000});
    samples_todo.push_back({32'h7fffffff, 32'h7fffffff});
    samples_todo.push_back({32'h80000000, 32'h80000000});
    samples_todo.push_back({32'h7fffffff, 32'h80000000});
    samples_todo.push_back({32'h80000000, 32'h7fffffff});
    samples_todo.push_back({32'hffffffff, 32'hffffffff});
    samples_todo.push_back({32'h00010000, 32'h00010000});
    samples_todo.push_back({32'hffff0000, 32'h00005a00});
    drain();
    // smallest registers, tiny period
    write_all(32'd0, 32'd0, 32'd1, 32'd1);
    samples_todo.push_back({32'h80000000, 32'h7fffffff});
    samples_todo.push_back({32'h7fffffff, 32'h80000000});
    samples_todo.push_back({32'h00000000, 32'h00000000});
    drain();
    // largest registers
    write_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    samples_todo.push_back({32'h7fffffff, 32'h7fffffff});
    samples_todo.push_back({32'h80000000, 32'h80000000});
    samples_todo.push_back({32'h80000000, 32'h7fffffff});
    samples_todo.push_back({32'h00000000, 32'hffffffff});
    drain();

    // random phases, the long hold-off falls in the first
    write_all(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST, SAMPLE_PERIOD_RST);
    queue_random(330);
    drain();
    write_all($urandom, $urandom, $urandom_range(32'hffffffff, 1),
              $urandom_range(32'hffffffff, 1));
    queue_random(120);
    drain();
    // a stretch with no idling on either side
    quiet = 1'b1;
    write_all($urandom_range(1 << 24), $urandom_range(1 << 22),
              $urandom_range(1 << 26, 1), $urandom_range(1 << 25, 1));
    queue_random(100);
    drain();
    quiet = 1'b0;
    write_all(32'hffffffff, 32'd0, 32'd1, $urandom_range(1 << 28, 1));
    queue_random(80);
    drain();
    write_all(32'd0, 32'hffffffff, 32'hffffffff, 32'd1);
    queue_random(80);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/akf_pkg.sv
rtl/akf_mul.sv
rtl/akf_div.sv
rtl/akf_dpath.sv
rtl/akf_ctrl.sv
rtl/angle_gyro_kalman_fusion.sv
sim/angle_gyro_kalman_fusion_test.sv
